[src/bisection_cubic_root_macros.svh]
`ifndef BISECTION_CUBIC_ROOT_MACROS_SVH
`define BISECTION_CUBIC_ROOT_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define BCR_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define BCR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/bcr_pkg.sv]
`default_nettype none

package bcr_pkg;

  localparam int WORD_W     = 32;
  localparam int FRAC_BITS  = 20;
  localparam int ACC_W      = 80;
  localparam int TOL_W      = WORD_W - 1;
  localparam int STEP_W     = 6;
  localparam int MAX_STEPS  = (1 << STEP_W) - 1;

  localparam int LIMB_W     = WORD_W;
  localparam int NUM_LIMBS  = (ACC_W + LIMB_W - 1) / LIMB_W;
  localparam int LIMB_IDX_W = (NUM_LIMBS > 1) ? $clog2(NUM_LIMBS) : 1;
  localparam int ACC_EXT_W  = NUM_LIMBS * LIMB_W;
  localparam int PP_W       = LIMB_W + 1 + WORD_W;
  localparam int PROD_W     = ACC_W + WORD_W;
  localparam int SHAMT_W    = $clog2(PROD_W);
  localparam int SUM_W      = PROD_W - FRAC_BITS + 1;

  localparam int NUM_HORNER = 3;
  localparam int COEF_IDX_W = 2;

  localparam logic [COEF_IDX_W-1:0] HORNER_SQUARE   = 2'd0;
  localparam logic [COEF_IDX_W-1:0] HORNER_LINEAR   = 2'd1;
  localparam logic [COEF_IDX_W-1:0] HORNER_CONSTANT = 2'd2;

  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_CUBIC    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_SQUARE   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_LINEAR   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_CONSTANT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE     = 3'd4;

  localparam logic signed [WORD_W-1:0] RST_COEF_CUBIC    = WORD_W'(-2883584);
  localparam logic signed [WORD_W-1:0] RST_COEF_SQUARE   = WORD_W'(18874368);
  localparam logic signed [WORD_W-1:0] RST_COEF_LINEAR   = WORD_W'(-22020096);
  localparam logic signed [WORD_W-1:0] RST_COEF_CONSTANT = WORD_W'(-12582912);
  localparam logic [TOL_W-1:0]         RST_TOLERANCE     = TOL_W'(10);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_ADD,
    ST_CHECK,
    ST_TEST,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    SIGN_ZERO = 2'd0,
    SIGN_POS  = 2'd1,
    SIGN_NEG  = 2'd2
  } sign_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] coef_cubic;
    logic signed [WORD_W-1:0] coef_square;
    logic signed [WORD_W-1:0] coef_linear;
    logic signed [WORD_W-1:0] coef_constant;
    logic [TOL_W-1:0]         tolerance;
  } cfg_t;

  typedef struct packed {
    logic                  load;
    logic                  acc_init;
    logic                  mul_en;
    logic [LIMB_IDX_W-1:0] limb;
    logic                  add_en;
    logic [COEF_IDX_W-1:0] coef_sel;
    logic                  eval_mid;
    logic                  set_lower_sign;
    logic                  update;
    logic                  advance;
  } dp_cmd_t;

  typedef struct packed {
    logic more;
  } dp_stat_t;

endpackage

`default_nettype wire

[src/bcr_ctrl.sv]
`default_nettype none

`include "bisection_cubic_root_macros.svh"

module bcr_ctrl (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   start,
  input  bcr_pkg::dp_stat_t     stat,
  output bcr_pkg::dp_cmd_t      cmd,
  output logic                  busy,
  output logic                  out_valid
);

  localparam logic [bcr_pkg::LIMB_IDX_W-1:0] LAST_LIMB =
    bcr_pkg::LIMB_IDX_W'(bcr_pkg::NUM_LIMBS - 1);
  localparam logic [bcr_pkg::COEF_IDX_W-1:0] LAST_COEF =
    bcr_pkg::COEF_IDX_W'(bcr_pkg::NUM_HORNER - 1);

  bcr_pkg::state_t                 state_r, state_nxt;
  logic [bcr_pkg::LIMB_IDX_W-1:0]  limb_r, limb_nxt;
  logic [bcr_pkg::COEF_IDX_W-1:0]  coef_r, coef_nxt;
  logic                            eval_mid_r, eval_mid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= bcr_pkg::ST_IDLE;
      limb_r     <= '0;
      coef_r     <= '0;
      eval_mid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      limb_r     <= limb_nxt;
      coef_r     <= coef_nxt;
      eval_mid_r <= eval_mid_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    limb_nxt     = limb_r;
    coef_nxt     = coef_r;
    eval_mid_nxt = eval_mid_r;
    cmd          = '0;
    cmd.limb     = limb_r;
    cmd.coef_sel = coef_r;
    cmd.eval_mid = eval_mid_r;
    unique case (state_r)
      bcr_pkg::ST_IDLE: begin
        if (start) begin
          cmd.load     = 1'b1;
          cmd.acc_init = 1'b1;
          eval_mid_nxt = 1'b0;
          limb_nxt     = '0;
          coef_nxt     = '0;
          state_nxt    = bcr_pkg::ST_MUL;
        end
      end
      bcr_pkg::ST_MUL: begin
        cmd.mul_en = 1'b1;
        if (limb_r == LAST_LIMB) begin
          limb_nxt  = '0;
          state_nxt = bcr_pkg::ST_ADD;
        end else begin
          limb_nxt = limb_r + 1'b1;
        end
      end
      bcr_pkg::ST_ADD: begin
        cmd.add_en = 1'b1;
        if (coef_r == LAST_COEF) begin
          coef_nxt  = '0;
          state_nxt = bcr_pkg::ST_CHECK;
        end else begin
          coef_nxt  = coef_r + 1'b1;
          state_nxt = bcr_pkg::ST_MUL;
        end
      end
      bcr_pkg::ST_CHECK: begin
        if (eval_mid_r) begin
          cmd.update = 1'b1;
        end else begin
          cmd.set_lower_sign = 1'b1;
        end
        state_nxt = bcr_pkg::ST_TEST;
      end
      bcr_pkg::ST_TEST: begin
        if (stat.more) begin
          cmd.advance  = 1'b1;
          cmd.acc_init = 1'b1;
          eval_mid_nxt = 1'b1;
          state_nxt    = bcr_pkg::ST_MUL;
        end else begin
          state_nxt = bcr_pkg::ST_DONE;
        end
      end
      bcr_pkg::ST_DONE: begin
        state_nxt = bcr_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = bcr_pkg::ST_IDLE;
      end
    endcase
  end

  assign busy      = (state_r != bcr_pkg::ST_IDLE);
  assign out_valid = (state_r == bcr_pkg::ST_DONE);

  `BCR_ASSERT_NEXT(a_strobe_single, out_valid, !out_valid, "Result strobe lasted two cycles.")
  `BCR_ASSERT_NEXT(a_accept_busy, start && !busy, busy && !out_valid, "Accepted item did not start.")
  `BCR_ASSERT_IMPL(a_limb_range, state_r == bcr_pkg::ST_MUL, limb_r <= LAST_LIMB, "Limb index out of range.")
  `BCR_ASSERT_NEXT(a_horner_loop, (state_r == bcr_pkg::ST_ADD) && (coef_r != LAST_COEF), (state_r == bcr_pkg::ST_MUL) && (limb_r == '0), "Horner step did not restart multiply.")

endmodule

`default_nettype wire

[src/bcr_dp.sv]
`default_nettype none

module bcr_dp (
  input  wire                                   clk,
  input  bcr_pkg::cfg_t                         cfg,
  input  bcr_pkg::dp_cmd_t                      cmd,
  output bcr_pkg::dp_stat_t                     stat,
  input  wire logic signed [bcr_pkg::WORD_W-1:0] in_left_end,
  input  wire logic signed [bcr_pkg::WORD_W-1:0] in_right_end,
  output logic signed [bcr_pkg::WORD_W-1:0]     out_root,
  output logic [bcr_pkg::STEP_W-1:0]            out_iterations
);

  localparam int W  = bcr_pkg::WORD_W;
  localparam int AW = bcr_pkg::ACC_W;
  localparam int PW = bcr_pkg::PROD_W;
  localparam int SW = bcr_pkg::SUM_W;
  localparam int HW = bcr_pkg::PROD_W - bcr_pkg::FRAC_BITS;

  localparam logic [bcr_pkg::LIMB_IDX_W-1:0] LAST_LIMB =
    bcr_pkg::LIMB_IDX_W'(bcr_pkg::NUM_LIMBS - 1);
  localparam logic signed [AW-1:0] SAT_MAX = {1'b0, {(AW-1){1'b1}}};
  localparam logic signed [AW-1:0] SAT_MIN = {1'b1, {(AW-1){1'b0}}};

  logic signed [W-1:0]              lower_r, upper_r, mid_r;
  logic [bcr_pkg::STEP_W-1:0]       steps_r;
  logic signed [AW-1:0]             acc_r;
  logic signed [PW-1:0]             prod_r;
  bcr_pkg::sign_t                   lower_sign_r;

  logic signed [W-1:0]              x;
  logic [bcr_pkg::ACC_EXT_W-1:0]    acc_ext;
  logic [bcr_pkg::LIMB_W-1:0]       limb_val;
  logic signed [bcr_pkg::LIMB_W:0]  op_a;
  logic signed [bcr_pkg::PP_W-1:0]  pp;
  logic [PW-1:0]                    pp_ext;
  logic [bcr_pkg::SHAMT_W-1:0]      shamt;
  logic [PW-1:0]                    prod_base;
  logic [PW-1:0]                    prod_nxt;

  logic [HW-1:0]                    prod_sh;
  logic signed [W-1:0]              coef;
  logic [SW-1:0]                    sum;
  logic [SW-AW:0]                   sum_hi;
  logic                             ovf;
  logic signed [AW-1:0]             acc_nxt;
  bcr_pkg::sign_t                   acc_sign;
  logic                             opposite;

  logic [W:0]                       pair_sum;
  logic signed [W-1:0]              mid_nxt;
  logic [W:0]                       diff;
  logic [W:0]                       abs_diff;
  logic [bcr_pkg::TOL_W-1:0]        tol_eff;

  always_comb begin
    x        = cmd.eval_mid ? mid_r : lower_r;
    acc_ext  = {{(bcr_pkg::ACC_EXT_W-AW){acc_r[AW-1]}}, acc_r};
    limb_val = acc_ext[cmd.limb*bcr_pkg::LIMB_W +: bcr_pkg::LIMB_W];
    op_a     = {(cmd.limb == LAST_LIMB) ? limb_val[bcr_pkg::LIMB_W-1] : 1'b0, limb_val};
  end

  assign pp = op_a * x;

  always_comb begin
    pp_ext    = {{(PW-bcr_pkg::PP_W){pp[bcr_pkg::PP_W-1]}}, pp};
    shamt     = bcr_pkg::SHAMT_W'(int'(cmd.limb) * bcr_pkg::LIMB_W);
    prod_base = (cmd.limb == '0) ? '0 : prod_r;
    prod_nxt  = prod_base + (pp_ext << shamt);
  end

  always_comb begin
    unique case (cmd.coef_sel)
      bcr_pkg::HORNER_SQUARE:   coef = cfg.coef_square;
      bcr_pkg::HORNER_LINEAR:   coef = cfg.coef_linear;
      default:                  coef = cfg.coef_constant;
    endcase
    prod_sh = prod_r[PW-1:bcr_pkg::FRAC_BITS];
    sum     = {prod_sh[HW-1], prod_sh} + {{(SW-W){coef[W-1]}}, coef};
    sum_hi  = sum[SW-1:AW-1];
    ovf     = !((&sum_hi) || !(|sum_hi));
    if (ovf) begin
      acc_nxt = sum[SW-1] ? SAT_MIN : SAT_MAX;
    end else begin
      acc_nxt = sum[AW-1:0];
    end
  end

  always_comb begin
    if (acc_r == '0) begin
      acc_sign = bcr_pkg::SIGN_ZERO;
    end else if (acc_r[AW-1]) begin
      acc_sign = bcr_pkg::SIGN_NEG;
    end else begin
      acc_sign = bcr_pkg::SIGN_POS;
    end
    opposite = (lower_sign_r != bcr_pkg::SIGN_ZERO) && (acc_sign != bcr_pkg::SIGN_ZERO) &&
               (lower_sign_r != acc_sign);
  end

  always_comb begin
    pair_sum = {lower_r[W-1], lower_r} + {upper_r[W-1], upper_r};
    mid_nxt  = pair_sum[W:1];
    diff     = {lower_r[W-1], lower_r} - {upper_r[W-1], upper_r};
    abs_diff = diff[W] ? (~diff + 1'b1) : diff;
    tol_eff  = (cfg.tolerance == '0) ? bcr_pkg::TOL_W'(1) : cfg.tolerance;
    stat.more = (abs_diff > {2'b00, tol_eff}) &&
                (steps_r != bcr_pkg::STEP_W'(bcr_pkg::MAX_STEPS));
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      lower_r <= in_left_end;
      upper_r <= in_right_end;
      mid_r   <= in_left_end;
      steps_r <= '0;
    end
    if (cmd.advance) begin
      mid_r   <= mid_nxt;
      steps_r <= steps_r + 1'b1;
    end
    if (cmd.update) begin
      if (opposite) begin
        upper_r <= mid_r;
      end else begin
        lower_r      <= mid_r;
        lower_sign_r <= acc_sign;
      end
    end
    if (cmd.set_lower_sign) begin
      lower_sign_r <= acc_sign;
    end
    if (cmd.acc_init) begin
      acc_r <= {{(AW-W){cfg.coef_cubic[W-1]}}, cfg.coef_cubic};
    end else if (cmd.add_en) begin
      acc_r <= acc_nxt;
    end
    if (cmd.mul_en) begin
      prod_r <= prod_nxt;
    end
  end

  assign out_root       = mid_r;
  assign out_iterations = steps_r;

endmodule

`default_nettype wire

[src/bisection_cubic_root.sv]
// Bisection root finder for a cubic with programmable Q12.20 coefficients. An item is an
// interval taken when start is high and busy is low; busy stays high until the result,
// the last midpoint and the number of halvings, is shown for one cycle with out_valid.
// The receiver cannot stall, so out_root and out_iterations must be captured in that cycle.
// Each polynomial evaluation runs three Horner steps on one shared 33 by 32 bit multiplier,
// three partial products and one add-and-saturate step per Horner step, and then the sign
// check and the interval test. Coefficients and tolerance are to be written through the
// cfg port by the user only while busy is low; the block itself does not enforce this,
// and cfg_ready is always high.

`default_nettype none

module bisection_cubic_root (
  input  wire                                   clk,
  input  wire                                   rst_n,
  input  wire                                   start,
  output logic                                  busy,
  input  wire logic signed [bcr_pkg::WORD_W-1:0] in_left_end,
  input  wire logic signed [bcr_pkg::WORD_W-1:0] in_right_end,
  output logic                                  out_valid,
  output logic signed [bcr_pkg::WORD_W-1:0]     out_root,
  output logic [bcr_pkg::STEP_W-1:0]            out_iterations,
  input  wire                                   cfg_valid,
  output logic                                  cfg_ready,
  input  wire [bcr_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  wire [bcr_pkg::WORD_W-1:0]             cfg_data
);

  bcr_pkg::cfg_t     cfg_r;
  bcr_pkg::dp_cmd_t  cmd;
  bcr_pkg::dp_stat_t stat;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.coef_cubic    <= bcr_pkg::RST_COEF_CUBIC;
      cfg_r.coef_square   <= bcr_pkg::RST_COEF_SQUARE;
      cfg_r.coef_linear   <= bcr_pkg::RST_COEF_LINEAR;
      cfg_r.coef_constant <= bcr_pkg::RST_COEF_CONSTANT;
      cfg_r.tolerance     <= bcr_pkg::RST_TOLERANCE;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        bcr_pkg::CFG_COEF_CUBIC:    cfg_r.coef_cubic    <= cfg_data;
        bcr_pkg::CFG_COEF_SQUARE:   cfg_r.coef_square   <= cfg_data;
        bcr_pkg::CFG_COEF_LINEAR:   cfg_r.coef_linear   <= cfg_data;
        bcr_pkg::CFG_COEF_CONSTANT: cfg_r.coef_constant <= cfg_data;
        bcr_pkg::CFG_TOLERANCE:     cfg_r.tolerance     <= cfg_data[bcr_pkg::TOL_W-1:0];
        default: begin
        end
      endcase
    end
  end

  bcr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .stat      (stat),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  bcr_dp u_dp (
    .clk            (clk),
    .cfg            (cfg_r),
    .cmd            (cmd),
    .stat           (stat),
    .in_left_end    (in_left_end),
    .in_right_end   (in_right_end),
    .out_root       (out_root),
    .out_iterations (out_iterations)
  );

endmodule

`default_nettype wire
